// ===== rtl/core/dmts_pkg.sv =====
`timescale 1ns / 1ps

package dmts_pkg;

  localparam int ROW_BITS = 8;
  localparam int COL_BITS = 8;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;
  localparam int CMD_ROW_W = 8;
  localparam int CMD_COL_W = 8;

  localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(65536);

  localparam logic [ADDR_W-1:0] ROW_MASK = ADDR_W'((1 << ROW_BITS) - 1);
  localparam logic [ADDR_W-1:0] COL_MASK = ADDR_W'((1 << COL_BITS) - 1);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_REPLY = 1'b1;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FILL  = 2'd1,
    PH_ONES  = 2'd2,
    PH_ZEROS = 2'd3
  } phase_t;

  typedef struct packed {
    logic mode;
    logic reply_bit;
  } item_t;

  typedef struct packed {
    logic                 result_kind;
    logic                 cmd_write;
    logic [CMD_ROW_W-1:0] cmd_row;
    logic [CMD_COL_W-1:0] cmd_col;
    logic                 cmd_data;
    logic                 fail_found;
    logic [ADDR_W-1:0]    fail_addr;
  } result_t;

endpackage

// ===== rtl/core/dram_march_test_sequencer.sv =====
// An accepted input word is held in the input stage register; its result word is registered in the output stage.
// Throughput: one input word per cycle while the output side keeps taking words.
// A reply word is processed by at most one compare or one address increment; a start word restarts at address 0.
// Reset (rst, synchronous, active high) empties both stages, sets the test size
// to 65536, returns the sequencer to idle and clears the failure records.
`timescale 1ns / 1ps

module dram_march_test_sequencer
  import dmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] reply_bit, [7:1] zero
  input  logic        s_axis_tuser,   // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] cmd_write, [8:1] cmd_row, [16:9] cmd_col,
                                      // [17] cmd_data, [18] fail_found, [34:19] fail_addr,
                                      // [39:35] zero
  output logic        m_axis_tuser    // [0] result_kind
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_free;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.mode = s_axis_tuser;
  assign in_item.reply_bit = s_axis_tdata[0];
  assign step = held_valid && out_free;

  dmts_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (out_free),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  dmts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  dmts_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (res_valid),
    .load_res   (res),
    .free       (out_free),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tuser = out_res.result_kind;
  assign m_axis_tdata = {5'b0, out_res.fail_addr, out_res.fail_found, out_res.cmd_data,
                         out_res.cmd_col, out_res.cmd_row, out_res.cmd_write};

endmodule

// ===== rtl/core/dmts_in_stage.sv =====
`timescale 1ns / 1ps

module dmts_in_stage
  import dmts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  logic  valid;
  item_t item;

  assign in_ready = !valid || take;
  assign held_valid = valid;
  assign held_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/dmts_ctrl.sv =====
`timescale 1ns / 1ps

module dmts_ctrl
  import dmts_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              step,
  input  item_t             item,
  output logic              res_valid,
  output result_t           res
);

  logic [SIZE_W-1:0] test_size;
  phase_t            phase, phase_next;
  logic [SIZE_W-1:0] address_index, address_index_next;
  logic              awaiting_read, awaiting_read_next;
  logic              pass_one_failed, pass_one_failed_next;
  logic [ADDR_W-1:0] pass_one_addr, pass_one_addr_next;
  logic              pass_two_failed, pass_two_failed_next;
  logic [ADDR_W-1:0] pass_two_addr, pass_two_addr_next;

  logic [SIZE_W-1:0] eff_size;
  logic [SIZE_W-1:0] idx_inc;
  logic              more;
  logic              expect_bit;

  function automatic result_t make_cmd(logic wr, logic [SIZE_W-1:0] addr, logic data);
    result_t           r;
    logic [ADDR_W-1:0] a;
    a = addr[ADDR_W-1:0];
    r = '0;
    r.result_kind = KIND_CMD;
    r.cmd_write = wr;
    r.cmd_row = CMD_ROW_W'(a & ROW_MASK);
    r.cmd_col = CMD_COL_W'((a >> ROW_BITS) & COL_MASK);
    r.cmd_data = wr & data;
    return r;
  endfunction

  always_comb begin
    if (test_size == '0) begin
      eff_size = SIZE_W'(1);
    end else if (test_size > FULL_SIZE) begin
      eff_size = FULL_SIZE;
    end else begin
      eff_size = test_size;
    end
  end

  assign idx_inc = address_index + SIZE_W'(1);
  assign more = idx_inc < eff_size;
  assign expect_bit = (phase == PH_ONES);

  always_comb begin
    phase_next = phase;
    address_index_next = address_index;
    awaiting_read_next = awaiting_read;
    pass_one_failed_next = pass_one_failed;
    pass_one_addr_next = pass_one_addr;
    pass_two_failed_next = pass_two_failed;
    pass_two_addr_next = pass_two_addr;
    res_valid = 1'b0;
    res = '0;
    if (step) begin
      if (item.mode == MODE_START) begin
        phase_next = PH_FILL;
        address_index_next = '0;
        awaiting_read_next = 1'b0;
        pass_one_failed_next = 1'b0;
        pass_one_addr_next = '0;
        pass_two_failed_next = 1'b0;
        pass_two_addr_next = '0;
        res_valid = 1'b1;
        res = make_cmd(1'b1, '0, 1'b1);
      end else begin
        unique case (phase)
          PH_IDLE: begin
            res_valid = 1'b0;
          end
          PH_FILL: begin
            res_valid = 1'b1;
            if (more) begin
              address_index_next = idx_inc;
              res = make_cmd(1'b1, idx_inc, 1'b1);
            end else begin
              phase_next = PH_ONES;
              address_index_next = '0;
              awaiting_read_next = 1'b1;
              res = make_cmd(1'b0, '0, 1'b0);
            end
          end
          PH_ONES, PH_ZEROS: begin
            res_valid = 1'b1;
            if (awaiting_read) begin
              if (item.reply_bit != expect_bit) begin
                if (phase == PH_ONES) begin
                  pass_one_failed_next = 1'b1;
                  pass_one_addr_next = address_index[ADDR_W-1:0];
                end else begin
                  pass_two_failed_next = 1'b1;
                  pass_two_addr_next = address_index[ADDR_W-1:0];
                end
              end
              awaiting_read_next = 1'b0;
              res = make_cmd(1'b1, address_index, !expect_bit);
            end else if (more) begin
              address_index_next = idx_inc;
              awaiting_read_next = 1'b1;
              res = make_cmd(1'b0, idx_inc, 1'b0);
            end else if (phase == PH_ONES) begin
              phase_next = PH_ZEROS;
              address_index_next = '0;
              awaiting_read_next = 1'b1;
              res = make_cmd(1'b0, '0, 1'b0);
            end else begin
              phase_next = PH_IDLE;
              address_index_next = '0;
              awaiting_read_next = 1'b0;
              res.result_kind = KIND_DONE;
              res.fail_found = pass_one_failed | pass_two_failed;
              if (pass_one_failed) begin
                res.fail_addr = pass_one_addr;
              end else if (pass_two_failed) begin
                res.fail_addr = pass_two_addr;
              end
            end
          end
          default: begin
            res_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      test_size <= FULL_SIZE;
      phase <= PH_IDLE;
      address_index <= '0;
      awaiting_read <= 1'b0;
      pass_one_failed <= 1'b0;
      pass_one_addr <= '0;
      pass_two_failed <= 1'b0;
      pass_two_addr <= '0;
    end else begin
      if (cfg_we) begin
        test_size <= cfg_data;
      end
      phase <= phase_next;
      address_index <= address_index_next;
      awaiting_read <= awaiting_read_next;
      pass_one_failed <= pass_one_failed_next;
      pass_one_addr <= pass_one_addr_next;
      pass_two_failed <= pass_two_failed_next;
      pass_two_addr <= pass_two_addr_next;
    end
  end

endmodule

// ===== rtl/core/dmts_out_stage.sv =====
`timescale 1ns / 1ps

module dmts_out_stage
  import dmts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load_valid,
  input  result_t load_res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid;
  result_t res;

  assign free = !valid || out_ready;
  assign out_valid = valid;
  assign out_res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/core/dmts_checker.sv =====
`timescale 1ns / 1ps

module dmts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output word valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled output word changed.");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[17:0] == 18'd0)
    else $error("Done word carries command fields.");

  a_cmd_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:18] == 22'd0)
    else $error("Command word carries verdict fields.");

  a_read_nodata: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && !m_axis_tdata[0] |-> !m_axis_tdata[17])
    else $error("Read command carries a data bit.");

endmodule

bind dram_march_test_sequencer dmts_checker u_dmts_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
